@@ rtl/core/lsse_pkg.sv @@
// ----------------------------------------------------------------------------
// lsse_pkg: shared constants for the longest exact-sum subarray unit
// Widths of the window store, its pointers, the length counters and the
// running total, plus the reset value of the target register.
// ----------------------------------------------------------------------------
package lsse_pkg;

  localparam int WindowDepth = 256;
  localparam int ValueBits   = 16;
  localparam int PtrBits     = $clog2(WindowDepth);
  localparam int CountBits   = $clog2(WindowDepth + 1);
  localparam int TargetBits  = 24;
  // Total holds up to WindowDepth full values and still compares above target
  localparam int TotalBits   = ((ValueBits + PtrBits) > TargetBits) ?
                               (ValueBits + PtrBits + 1) : (TargetBits + 1);
  localparam int LenBits     = 9;

  localparam logic [TargetBits-1:0] TargetReset = TargetBits'(15);

endpackage

@@ rtl/core/lsse_window_ram.sv @@
// ----------------------------------------------------------------------------
// lsse_window_ram: window FIFO storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lsse_window_ram import lsse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [PtrBits-1:0]   waddr_i,
  input  logic [ValueBits-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [PtrBits-1:0]   raddr_i,
  output logic [ValueBits-1:0] rdata_o
);

  logic [ValueBits-1:0] mem_q [WindowDepth];
  logic [ValueBits-1:0] rdata_q;

  // write new element
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // register read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/longest_subarray_exact_sum_unit.sv @@
// ----------------------------------------------------------------------------
// longest_subarray_exact_sum_unit: longest contiguous run with exact sum
// Streams non-negative values through a sliding window kept in a RAM FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries value_i and last_i. Each
//   request yields exactly one result on the output channel
//   (out_valid_o/out_ready_i): best_length_o, window_length_o, is_last_o and
//   overflow_o. A request with last_i set closes the array; its result is
//   reported and the window, total and best length are then cleared.
//   The target is written through cfg_we_i/cfg_wdata_i while idle; the user
//   must keep to this, as the block itself does not enforce it.
// Sequencing:
//   An item is appended, then compared and its result issued. Every element
//   removed from the window on the way is a RAM read followed by the total
//   update. A full window first has its oldest element read, then dropped
//   in the same step as the append. Each element is removed at most once.
//   in_ready_o is high only while no item is in work.
// Reset: window empty, best length zero, target 15; no result pending.
// Stall: a result waits in the output register while out_ready_i is low;
//   the next request may be accepted meanwhile and completes once the
//   output register is free.
// ----------------------------------------------------------------------------
module longest_subarray_exact_sum_unit import lsse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TargetBits-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LenBits-1:0]    best_length_o,
  output logic [LenBits-1:0]    window_length_o,
  output logic                  is_last_o,
  output logic                  overflow_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDrop   = 2'd1;
  localparam logic [1:0] StCheck  = 2'd2;
  localparam logic [1:0] StShrink = 2'd3;

  localparam logic [CountBits-1:0] FullCount = CountBits'(WindowDepth);

  function automatic logic [PtrBits-1:0] ptr_next(input logic [PtrBits-1:0] p);
    logic [PtrBits-1:0] r;
    if (p == PtrBits'(WindowDepth - 1)) r = '0;
    else                                r = p + PtrBits'(1);
    return r;
  endfunction

  logic [1:0]            state_q, state_d;
  logic [TargetBits-1:0] target_q;
  logic [PtrBits-1:0]    oldest_q, oldest_d, newest_q, newest_d;
  logic [CountBits-1:0]  count_q, count_d, best_q, best_d;
  logic [TotalBits-1:0]  total_q, total_d;
  logic [ValueBits-1:0]  value_q;
  logic                  last_q, ovf_q, ovf_d;
  logic                  out_valid_q, out_valid_d;
  logic [LenBits-1:0]    out_best_q, out_best_d, out_win_q, out_win_d;
  logic                  out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  logic                  in_fire, out_free, shrink_need, hit;
  logic                  ram_we, ram_re;
  logic [PtrBits-1:0]    ram_waddr, ram_raddr;
  logic [ValueBits-1:0]  ram_wdata, ram_rdata;
  logic [ValueBits-1:0]  in_value;
  logic [CountBits-1:0]  best_new;

  assign in_value    = value_i[ValueBits-1:0];
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign shrink_need = (total_q > TotalBits'(target_q)) && (count_q != '0);
  assign hit         = (total_q == TotalBits'(target_q)) && (count_q > best_q);
  assign best_new    = hit ? count_q : best_q;

  lsse_window_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequence append, drop and shrink steps
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    count_d     = count_q;
    total_d     = total_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_best_d  = out_best_q;
    out_win_d   = out_win_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = newest_q;
    ram_wdata   = in_value;
    ram_re      = 1'b0;
    ram_raddr   = oldest_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (count_q == FullCount) begin
            // fetch oldest before it is overwritten
            ram_re  = 1'b1;
            state_d = StDrop;
          end else begin
            ram_we   = 1'b1;
            newest_d = ptr_next(newest_q);
            count_d  = count_q + CountBits'(1);
            total_d  = total_q + TotalBits'(in_value);
            ovf_d    = 1'b0;
            state_d  = StCheck;
          end
        end
      end
      StDrop: begin
        // drop oldest and append in the same step; count stays full
        ram_we    = 1'b1;
        ram_wdata = value_q;
        newest_d  = ptr_next(newest_q);
        oldest_d  = ptr_next(oldest_q);
        total_d   = total_q - TotalBits'(ram_rdata) + TotalBits'(value_q);
        ovf_d     = 1'b1;
        state_d   = StCheck;
      end
      StCheck: begin
        if (shrink_need) begin
          ram_re  = 1'b1;
          state_d = StShrink;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_best_d  = LenBits'(best_new);
          out_win_d   = LenBits'(count_q);
          out_last_d  = last_q;
          out_ovf_d   = ovf_q;
          best_d      = best_new;
          state_d     = StIdle;
          if (last_q) begin
            // close the array
            oldest_d = '0;
            newest_d = '0;
            count_d  = '0;
            total_d  = '0;
            best_d   = '0;
          end
        end
      end
      StShrink: begin
        total_d  = total_q - TotalBits'(ram_rdata);
        oldest_d = ptr_next(oldest_q);
        count_d  = count_q - CountBits'(1);
        state_d  = StCheck;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      target_q    <= TargetReset;
      oldest_q    <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      total_q     <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      count_q     <= count_d;
      total_q     <= total_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_q <= in_value;
      last_q  <= last_i;
    end
    out_best_q <= out_best_d;
    out_win_q  <= out_win_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign best_length_o   = out_best_q;
  assign window_length_o = out_win_q;
  assign is_last_o       = out_last_q;
  assign overflow_o      = out_ovf_q;

endmodule

@@ rtl/core/lsse_checker.sv @@
// ----------------------------------------------------------------------------
// lsse_checker: port-level checks for the longest exact-sum subarray unit
// Watches the channels only and is attached to the top level by bind.
// ----------------------------------------------------------------------------
module lsse_checker import lsse_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [LenBits-1:0]    best_length_o,
  input logic [LenBits-1:0]    window_length_o,
  input logic                  is_last_o,
  input logic                  overflow_o
);

  // one request at a time: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o stayed high after a request");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_length_o) &&
    $stable(window_length_o) && $stable(is_last_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // lengths never exceed the window capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_length_o <= LenBits'(WindowDepth)) &&
    (best_length_o <= LenBits'(WindowDepth)))
    else $error("length beyond window capacity");

  // a fresh result frees the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("input not ready when a new result appeared");

endmodule

bind longest_subarray_exact_sum_unit lsse_checker u_lsse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .best_length_o   (best_length_o),
  .window_length_o (window_length_o),
  .is_last_o       (is_last_o),
  .overflow_o      (overflow_o)
);

@@ verif/longest_subarray_exact_sum_unit_test.sv @@
// ----------------------------------------------------------------------------
// longest_subarray_exact_sum_unit_test: self-checking bench for the unit
// Drives arrays of values with random gaps and output stalls. A local copy of
// the sliding window predicts every result, and the checker compares the
// results field by field in order. The target register is rewritten between
// phases, always while the unit is idle.
// ----------------------------------------------------------------------------
module longest_subarray_exact_sum_unit_test;
  import lsse_pkg::*;

  typedef struct packed {
    logic [LenBits-1:0] best;
    logic [LenBits-1:0] wlen;
    logic               is_last;
    logic               ovf;
  } window_result_t;

  localparam int RandomRequests = 1200;
  localparam int MaxShown       = 10;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [TargetBits-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           value_i     = '0;
  logic                  last_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [LenBits-1:0]    best_length_o;
  logic [LenBits-1:0]    window_length_o;
  logic                  is_last_o;
  logic                  overflow_o;

  // Local copy of the window state
  logic [ValueBits-1:0]  win_vals [WindowDepth];
  logic [PtrBits-1:0]    tail_ptr;
  logic [PtrBits-1:0]    head_ptr;
  logic [CountBits-1:0]  win_count;
  logic [TotalBits-1:0]  win_total;
  logic [LenBits-1:0]    best_len;
  logic [TargetBits-1:0] target_sum_q = TargetReset;

  window_result_t pending_results [$];
  int  mismatches      = 0;
  int  results_checked = 0;
  int  requests_sent   = 0;
  int  overflow_hits   = 0;
  int  arrays_closed   = 0;
  bit  idle_free       = 1'b0;

  longest_subarray_exact_sum_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_length_o  (best_length_o),
    .window_length_o(window_length_o),
    .is_last_o      (is_last_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Window predictor
  // ------------------------------------------------------------------------
  function automatic logic [PtrBits-1:0] next_ptr(logic [PtrBits-1:0] p);
    return (p == PtrBits'(WindowDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Take the oldest element off the window
  function automatic void pop_oldest();
    if (win_count != 0) begin
      win_total = win_total - TotalBits'(win_vals[tail_ptr]);
      tail_ptr  = next_ptr(tail_ptr);
      win_count = win_count - 1'b1;
    end
  endfunction

  function automatic void clear_window();
    tail_ptr  = '0;
    head_ptr  = '0;
    win_count = '0;
    win_total = '0;
    best_len  = '0;
  endfunction

  function automatic window_result_t compute_window_result(logic [15:0] v, logic l);
    window_result_t r;
    r.ovf = 1'b0;
    // Drop the oldest element when the window is full
    if (win_count >= WindowDepth) begin
      pop_oldest();
      r.ovf = 1'b1;
    end
    win_vals[head_ptr] = v[ValueBits-1:0];
    head_ptr  = next_ptr(head_ptr);
    win_count = win_count + 1'b1;
    win_total = win_total + TotalBits'(v[ValueBits-1:0]);
    // Shrink until the total fits, but never past an empty window
    while (win_total > TotalBits'(target_sum_q) && win_count != 0) pop_oldest();
    if (win_total == TotalBits'(target_sum_q) && win_count > best_len)
      best_len = LenBits'(win_count);
    r.best    = best_len;
    r.wlen    = LenBits'(win_count);
    r.is_last = l;
    if (l) clear_window();
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Shared drivers
  // ------------------------------------------------------------------------
  function automatic int draw_delay();
    return idle_free ? 0 : $urandom_range(0, 14);
  endfunction

  // Send one request; return at the falling edge after its acceptance
  task automatic send_request(input logic [15:0] v, input logic l);
    int gap;
    window_result_t exp_res;
    gap = draw_delay();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = compute_window_result(v, l);
    pending_results.insert(pending_results.size(), exp_res);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_target(input logic [TargetBits-1:0] t);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    target_sum_q = t;
  endtask

  // Stall the result channel by a random count per result
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_delay();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare each accepted result with the oldest prediction
  initial begin
    window_result_t got;
    window_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{best_length_o, window_length_o, is_last_o, overflow_o};
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("Unexpected result: best %0d window %0d last %0b overflow %0b",
                     got.best, got.wlen, got.is_last, got.ovf);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display({"Result %0d (expected/actual): best %0d/%0d window %0d/%0d",
                        " last %0b/%0b overflow %0b/%0b"}, results_checked,
                       want.best, got.best, want.wlen, got.wlen,
                       want.is_last, got.is_last, want.ovf, got.ovf);
          end
          if (want.ovf) overflow_hits++;
          if (want.is_last) arrays_closed++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Reset target of 15: match of two, then a shrink back to one
  task automatic test_reset_target();
    send_request(16'd5, 1'b0);
    send_request(16'd10, 1'b0);
    send_request(16'd15, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  // Full-scale values, an element alone above the target empties the window
  task automatic test_extremes();
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
    write_target({TargetBits{1'b1}});
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b1);
    write_target(24'h00FFFF);
    send_request(16'hFFFF, 1'b1);
    write_target(24'd1);
    send_request(16'd1, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b1);
  endtask

  // Target zero: empty window never counts, runs of zeros do
  task automatic test_zero_target();
    write_target('0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd7, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  // Fill the window past its depth so the oldest element is dropped
  task automatic test_window_overflow();
    int i;
    write_target({TargetBits{1'b1}});
    for (i = 0; i < WindowDepth + 40; i++) send_request(16'($urandom), 1'b0);
    send_request(16'($urandom), 1'b1);
    // Sparse ones against a small target make the window shrink each time the total passes it
    write_target(24'd4);
    for (i = 0; i < WindowDepth + 30; i++)
      send_request(($urandom_range(0, 19) == 0) ? 16'd1 : 16'd0, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  // Random arrays, values scaled to the target so that matches occur
  task automatic test_random_arrays();
    int sent;
    int arrays;
    int len;
    int scale;
    int i;
    logic [TargetBits-1:0] t;
    logic [15:0]           v;
    sent   = 0;
    arrays = 0;
    t      = target_sum_q;
    while (sent < RandomRequests) begin
      // Move to a new target every six arrays
      if (arrays % 6 == 0) begin
        case ($urandom_range(0, 5))
          0:       t = '0;
          1:       t = TargetBits'($urandom_range(1, 16));
          2:       t = TargetBits'($urandom_range(17, 4096));
          3:       t = TargetBits'($urandom_range(4097, 24'hFFFFFF));
          4:       t = {TargetBits{1'b1}};
          default: t = TargetBits'($urandom);
        endcase
        write_target(t);
      end
      scale = int'(t) / $urandom_range(1, 8);
      if (scale > 65535) scale = 65535;
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 40);
      idle_free = ($urandom_range(0, 5) == 0);
      for (i = 0; i < len; i++) begin
        // Mostly scaled values, with some full-width noise
        v = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, scale));
        send_request(v, i == len - 1);
      end
      sent += len;
      arrays++;
    end
    idle_free = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    clear_window();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_target();
    test_extremes();
    test_zero_target();
    test_window_overflow();
    test_random_arrays();

    drain_requests();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests in %0d arrays; checked %0d results, %0d with overflow",
             requests_sent, arrays_closed, results_checked, overflow_hits);
    $display("Targets covered zero, one, small, wide and full scale; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lsse_pkg.sv
rtl/core/lsse_window_ram.sv
rtl/core/longest_subarray_exact_sum_unit.sv
rtl/core/lsse_checker.sv
verif/longest_subarray_exact_sum_unit_test.sv
